FILE: rtl/string_to_integer_parser_macros.svh
// Assertion macros used by the checker file.
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

FILE: rtl/sip_pkg.sv
`default_nettype none

package sip_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int BASE_W = 6;
    localparam int OUT_W = 64;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_BASE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_SIGNED = 2'd1;
    localparam logic [1:0] CFG_NARROW = 2'd2;

    // Characters with a special meaning.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_O_UP  = 8'h4F;
    localparam logic [7:0] CH_O_LO  = 8'h6F;

    localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd63;

    // Digit value of a character up to base 36; NOT_DIGIT for anything else.
    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        begin
            d = NOT_DIGIT;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = BASE_W'(c - 8'h30);
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                d = BASE_W'(c - 8'h57);
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                d = BASE_W'(c - 8'h37);
            end
            return d;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/string_to_integer_parser.sv
// Flow: an accepted word sits in the input register and is parsed there; the result
// of a string is registered in the result register once its last word leaves the input
// register, which holds that word while the finished result is stalled.
// Throughput: one word per cycle unless the input stalls, set by the multiply-add step.
// Reset: asynchronous, active low; clears the string state and loads base 10,
// signed mode on and narrow mode off.
`default_nettype none

module string_to_integer_parser #(
    parameter int VALUE_WIDTH = sip_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [sip_pkg::BASE_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  char_code,
    input  wire logic                        char_present,
    input  wire logic                        end_of_string,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [sip_pkg::OUT_W-1:0]        value,
    output logic [1:0]                       status
);
    import sip_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int PW = VALUE_WIDTH + 7;
    localparam int NW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic [OUT_W-1:0] WMAX = {OUT_W{1'b1}} >> (OUT_W - VALUE_WIDTH);
    localparam logic [OUT_W-1:0] LIM_WIDE = WMAX >> 1;
    localparam logic [OUT_W-1:0] LIM_NARROW = {OUT_W{1'b1}} >> (OUT_W + 1 - NW);

    // Last character class seen by the underscore spacing check.
    localparam logic [1:0] CLS_START = 2'd0;
    localparam logic [1:0] CLS_DIGIT = 2'd1;
    localparam logic [1:0] CLS_UNDER = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    typedef enum logic [1:0] {PH_START, PH_SIGNED, PH_ZERO, PH_BODY} phase_t;

    // Configuration.
    logic [BASE_W-1:0] base_sel_reg;
    logic              signed_reg;
    logic              narrow_reg;

    // Input register.
    logic              in_v_reg;
    logic [7:0]        char_reg;
    logic              present_reg;
    logic              eos_reg;

    // String state.
    logic [W-1:0]      acc_reg, acc_next;
    logic [BASE_W-1:0] ebase_reg, ebase_next;
    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic              dseen_reg, dseen_next;
    logic              useen_reg, useen_next;
    logic [1:0]        err_reg, err_next;
    logic [1:0]        sp_last_reg, sp_last_next;
    logic              sp_hex_reg, sp_hex_next;
    logic              sp_bad_reg, sp_bad_next;

    // Result register.
    logic              out_v_reg, out_v_next;
    logic [OUT_W-1:0]  value_reg, value_next;
    logic [1:0]        status_reg, status_next;

    logic              advance;
    logic              do_body;
    logic              do_space;
    logic              hexletter;
    logic [BASE_W-1:0] dig;
    logic [PW-1:0]     mac;
    logic [1:0]        fin_err;
    logic [OUT_W-1:0]  acc_ext;
    logic [OUT_W-1:0]  lim;
    logic [OUT_W-1:0]  lim_p1;
    logic              bad_base;

    // The input word holds only when it ends a string and the finished result is stalled.
    assign advance  = in_v_reg && !(eos_reg && out_v_reg && out_stall);
    assign in_stall = in_v_reg && !advance;

    assign bad_base  = (base_sel_reg == BASE_W'(1)) || (base_sel_reg > BASE_W'(36));
    assign hexletter = (char_reg >= 8'h61 && char_reg <= 8'h66) ||
                       (char_reg >= 8'h41 && char_reg <= 8'h46);
    assign dig       = digit_of(char_reg);

    always_comb
    begin
        acc_next     = acc_reg;
        ebase_next   = ebase_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        dseen_next   = dseen_reg;
        useen_next   = useen_reg;
        err_next     = err_reg;
        sp_last_next = sp_last_reg;
        sp_hex_next  = sp_hex_reg;
        sp_bad_next  = sp_bad_reg;
        do_body      = 1'b0;
        do_space     = 1'b0;
        mac          = '0;

        if (advance && present_reg && err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_START, PH_SIGNED:
                begin
                    if (phase_reg == PH_START && signed_reg &&
                        (char_reg == CH_PLUS || char_reg == CH_MINUS))
                    begin
                        neg_next   = (char_reg == CH_MINUS);
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        if (bad_base)
                        begin
                            err_next = ST_BASE;
                        end
                        else if (base_sel_reg == '0)
                        begin
                            if (char_reg == CH_ZERO)
                            begin
                                phase_next = PH_ZERO;
                                do_space   = 1'b1;
                            end
                            else
                            begin
                                ebase_next = BASE_W'(10);
                                do_body    = 1'b1;
                            end
                        end
                        else
                        begin
                            ebase_next = base_sel_reg;
                            do_body    = 1'b1;
                        end
                    end
                end
                PH_ZERO:
                begin
                    phase_next = PH_BODY;
                    if (char_reg == CH_X_LO || char_reg == CH_X_UP)
                    begin
                        ebase_next  = BASE_W'(16);
                        sp_hex_next = 1'b1;
                    end
                    else if (char_reg == CH_B_LO || char_reg == CH_B_UP)
                    begin
                        ebase_next = BASE_W'(2);
                    end
                    else if (char_reg == CH_O_LO || char_reg == CH_O_UP)
                    begin
                        ebase_next = BASE_W'(8);
                    end
                    else
                    begin
                        ebase_next = BASE_W'(8);
                        dseen_next = 1'b1;
                        do_body    = 1'b1;
                    end
                end
                default:
                begin
                    do_body = 1'b1;
                end
            endcase

            if (do_body)
            begin
                do_space = 1'b1;
                if (char_reg == CH_UNDER && base_sel_reg == '0)
                begin
                    useen_next = 1'b1;
                end
                else if (ebase_next < BASE_W'(2) || dig >= ebase_next)
                begin
                    err_next = ST_SYNTAX;
                end
                else
                begin
                    // Overflow shows as any set bit above the value width.
                    mac = PW'(acc_reg) * PW'(ebase_next) + PW'(dig);
                    if (|mac[PW-1:W])
                    begin
                        err_next = ST_RANGE;
                    end
                    else
                    begin
                        acc_next   = mac[W-1:0];
                        dseen_next = 1'b1;
                    end
                end
            end

            // Underscore spacing: an underscore must follow a digit and be followed by one.
            if (do_space)
            begin
                if ((char_reg >= 8'h30 && char_reg <= 8'h39) || (sp_hex_next && hexletter))
                begin
                    sp_last_next = CLS_DIGIT;
                end
                else if (char_reg == CH_UNDER)
                begin
                    if (sp_last_reg != CLS_DIGIT)
                    begin
                        sp_bad_next = 1'b1;
                    end
                    sp_last_next = CLS_UNDER;
                end
                else
                begin
                    if (sp_last_reg == CLS_UNDER)
                    begin
                        sp_bad_next = 1'b1;
                    end
                    sp_last_next = CLS_OTHER;
                end
            end
        end

        // End of string: settle the status and the value.
        fin_err = err_next;
        if (phase_next == PH_START || phase_next == PH_SIGNED)
        begin
            fin_err = ST_SYNTAX;
        end
        else if (err_next == ST_OK && !dseen_next && phase_next != PH_ZERO)
        begin
            fin_err = ST_SYNTAX;
        end
        else if (err_next == ST_OK && useen_next &&
                 (sp_bad_next || sp_last_next == CLS_UNDER))
        begin
            fin_err = ST_SYNTAX;
        end

        acc_ext     = OUT_W'(acc_next);
        lim         = narrow_reg ? LIM_NARROW : LIM_WIDE;
        lim_p1      = lim + OUT_W'(1);
        value_next  = '0;
        status_next = fin_err;
        if (!signed_reg)
        begin
            if (fin_err == ST_OK)
            begin
                value_next = acc_ext;
            end
            else if (fin_err == ST_RANGE)
            begin
                value_next = WMAX;
            end
        end
        else
        begin
            if (fin_err == ST_OK)
            begin
                if (neg_next ? (acc_ext > lim_p1) : (acc_ext > lim))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    value_next = neg_next ? (OUT_W'(0) - acc_ext) : acc_ext;
                end
            end
            if (status_next == ST_RANGE)
            begin
                value_next = neg_next ? (OUT_W'(0) - lim_p1) : lim;
            end
        end

        if (advance && eos_reg)
        begin
            out_v_next   = 1'b1;
            acc_next     = '0;
            ebase_next   = '0;
            phase_next   = PH_START;
            neg_next     = 1'b0;
            dseen_next   = 1'b0;
            useen_next   = 1'b0;
            err_next     = ST_OK;
            sp_last_next = CLS_START;
            sp_hex_next  = 1'b0;
            sp_bad_next  = 1'b0;
        end
        else
        begin
            out_v_next  = out_v_reg && out_stall;
            value_next  = value_reg;
            status_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_sel_reg <= BASE_W'(10);
            signed_reg   <= 1'b1;
            narrow_reg   <= 1'b0;
            in_v_reg     <= 1'b0;
            char_reg     <= '0;
            present_reg  <= 1'b0;
            eos_reg      <= 1'b0;
            acc_reg      <= '0;
            ebase_reg    <= '0;
            phase_reg    <= PH_START;
            neg_reg      <= 1'b0;
            dseen_reg    <= 1'b0;
            useen_reg    <= 1'b0;
            err_reg      <= ST_OK;
            sp_last_reg  <= CLS_START;
            sp_hex_reg   <= 1'b0;
            sp_bad_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            value_reg    <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:   base_sel_reg <= cfg_data;
                    CFG_SIGNED: signed_reg   <= cfg_data[0];
                    CFG_NARROW: narrow_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (!in_stall)
            begin
                in_v_reg    <= in_valid;
                char_reg    <= char_code;
                present_reg <= char_present;
                eos_reg     <= end_of_string;
            end
            acc_reg     <= acc_next;
            ebase_reg   <= ebase_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            dseen_reg   <= dseen_next;
            useen_reg   <= useen_next;
            err_reg     <= err_next;
            sp_last_reg <= sp_last_next;
            sp_hex_reg  <= sp_hex_next;
            sp_bad_reg  <= sp_bad_next;
            out_v_reg   <= out_v_next;
            value_reg   <= value_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = out_v_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

FILE: rtl/sip_checker.sv
`default_nettype none

`include "string_to_integer_parser_macros.svh"

module sip_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        end_of_string,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [sip_pkg::OUT_W-1:0]   value,
    input wire logic [1:0]                  status
);
    import sip_pkg::*;

    // A held result keeps its word.
    `SIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(value) && $stable(status))

    // Input back-pressure only comes from a stalled result.
    `SIP_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A new result stems from an accepted end-of-string word.
    `SIP_ASSERT_NOW(a_result_src, clk, rst_n, $rose(out_valid),
        $past(in_valid && !in_stall && end_of_string, 2))

    // Syntax and base errors carry a zero value.
    `SIP_ASSERT_NOW(a_err_zero, clk, rst_n,
        out_valid && (status == ST_SYNTAX || status == ST_BASE), value == '0)

endmodule

bind string_to_integer_parser sip_checker u_sip_checker (.*);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import sip_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int NARROW_W = (VW < 32) ? VW : 32;
    localparam logic [63:0] WIDTH_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VW);
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 18;

    // Index 3 is not decoded by the block; a write there must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_Z_LO = 8'h7A;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_Z_UP = 8'h5A;

    typedef enum logic [1:0] {PH_START, PH_SIGNED, PH_ZERO, PH_BODY} scan_phase_t;
    typedef enum logic [1:0] {CLS_START, CLS_DIGIT, CLS_UNDER, CLS_OTHER} char_class_t;

    class parse_scoreboard;
        logic [5:0]  base_sel;
        bit          sign_mode;
        bit          narrow;
        logic [63:0] acc;
        logic [5:0]  radix;
        scan_phase_t phase;
        bit          negative;
        bit          any_digit;
        bit          any_underscore;
        logic [1:0]  fault;
        char_class_t last_class;
        bit          hex_spacing;
        bit          bad_spacing;
        logic [63:0] expected_values[$];
        logic [1:0]  expected_status[$];
        int          mismatches;

        function new();
            base_sel = 6'd10;
            sign_mode = 1'b1;
            narrow = 1'b0;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            acc = '0;
            radix = '0;
            phase = PH_START;
            negative = 1'b0;
            any_digit = 1'b0;
            any_underscore = 1'b0;
            fault = ST_OK;
            last_class = CLS_START;
            hex_spacing = 1'b0;
            bad_spacing = 1'b0;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function logic [5:0] digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return 6'(c - CH_ZERO);
            if (c >= CH_A_LO && c <= CH_Z_LO)
                return 6'(c - CH_A_LO + 8'd10);
            if (c >= CH_A_UP && c <= CH_Z_UP)
                return 6'(c - CH_A_UP + 8'd10);
            return NOT_DIGIT;
        endfunction

        // Underscores are legal only between digits, or right after a radix prefix.
        function void feed_spacing(logic [7:0] c);
            bit hex_letter;
            hex_letter = (c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP);
            if ((c >= CH_ZERO && c <= CH_NINE) || (hex_spacing && hex_letter))
            begin
                last_class = CLS_DIGIT;
            end
            else if (c == CH_UNDER)
            begin
                if (last_class != CLS_DIGIT)
                    bad_spacing = 1'b1;
                last_class = CLS_UNDER;
            end
            else
            begin
                if (last_class == CLS_UNDER)
                    bad_spacing = 1'b1;
                last_class = CLS_OTHER;
            end
        endfunction

        function void body_char(logic [7:0] c);
            logic [63:0] b;
            logic [63:0] d;
            b = 64'(radix);
            if (c == CH_UNDER && base_sel == 6'd0)
            begin
                any_underscore = 1'b1;
                feed_spacing(c);
                return;
            end
            feed_spacing(c);
            d = 64'(digit_value(c));
            if (b < 2 || d >= b)
            begin
                fault = ST_SYNTAX;
                return;
            end
            if (acc > WIDTH_MAX / b || (acc == WIDTH_MAX / b && d > WIDTH_MAX % b))
            begin
                fault = ST_RANGE;
                return;
            end
            acc = acc * b + d;
            any_digit = 1'b1;
        endfunction

        function void take_char(logic [7:0] c);
            if (fault != ST_OK)
                return;
            if (phase == PH_START && sign_mode && (c == CH_PLUS || c == CH_MINUS))
            begin
                negative = (c == CH_MINUS);
                phase = PH_SIGNED;
                return;
            end
            if (phase == PH_START || phase == PH_SIGNED)
            begin
                phase = PH_BODY;
                if (base_sel == 6'd1 || base_sel > 6'd36)
                begin
                    fault = ST_BASE;
                    return;
                end
                if (base_sel == 6'd0)
                begin
                    if (c == CH_ZERO)
                    begin
                        phase = PH_ZERO;
                        feed_spacing(c);
                        return;
                    end
                    radix = 6'd10;
                end
                else
                begin
                    radix = base_sel;
                end
                body_char(c);
                return;
            end
            if (phase == PH_ZERO)
            begin
                phase = PH_BODY;
                if (c == CH_X_LO || c == CH_X_UP)
                begin
                    radix = 6'd16;
                    hex_spacing = 1'b1;
                    return;
                end
                if (c == CH_B_LO || c == CH_B_UP)
                begin
                    radix = 6'd2;
                    return;
                end
                if (c == CH_O_LO || c == CH_O_UP)
                begin
                    radix = 6'd8;
                    return;
                end
                // A leading zero followed by anything else means octal.
                radix = 6'd8;
                any_digit = 1'b1;
                body_char(c);
                return;
            end
            body_char(c);
        endfunction

        function void note_word(logic [7:0] c, logic present, logic last);
            logic [1:0]  st;
            logic [63:0] v;
            logic [63:0] lim;
            if (present)
                take_char(c);
            if (!last)
                return;
            if (phase == PH_ZERO)
            begin
                radix = 6'd8;
                any_digit = 1'b1;
            end
            st = fault;
            if (phase == PH_START || phase == PH_SIGNED)
                st = ST_SYNTAX;
            else if (st == ST_OK && !any_digit)
                st = ST_SYNTAX;
            else if (st == ST_OK && any_underscore && (bad_spacing || last_class == CLS_UNDER))
                st = ST_SYNTAX;
            v = '0;
            if (!sign_mode)
            begin
                if (st == ST_OK)
                    v = acc;
                else if (st == ST_RANGE)
                    v = WIDTH_MAX;
            end
            else
            begin
                lim = narrow ? (64'hFFFF_FFFF_FFFF_FFFF >> (65 - NARROW_W)) : (WIDTH_MAX >> 1);
                if (st == ST_OK)
                begin
                    if (negative ? (acc > lim + 64'd1) : (acc > lim))
                        st = ST_RANGE;
                    else
                        v = negative ? (64'd0 - acc) : acc;
                end
                if (st == ST_RANGE)
                    v = negative ? (64'd0 - (lim + 64'd1)) : lim;
            end
            expected_values.push_back(v);
            expected_status.push_back(st);
            clear();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [63:0] v, logic [1:0] st);
            logic [63:0] want_v;
            logic [1:0]  want_st;
            if (expected_values.size() == 0)
            begin
                report($sformatf("unexpected result value=%h status=%0d", v, st));
                return;
            end
            want_v = expected_values.pop_front();
            want_st = expected_status.pop_front();
            if (v !== want_v)
                report($sformatf("value %h, expected %h", v, want_v));
            if (st !== want_st)
                report($sformatf("status %0d, expected %0d", st, want_st));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        char_present;
    logic        end_of_string;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic [1:0]  status;

    parse_scoreboard sb;
    logic [7:0] text[$];
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    logic [5:0] cur_base;
    bit cur_signed;

    string_to_integer_parser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_code(char_code),
        .char_present(char_present),
        .end_of_string(end_of_string),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(value, status);
            if (in_valid && !in_stall)
                sb.note_word(char_code, char_present, end_of_string);
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** string_to_integer_parser: FAILED **");
        $finish;
    end

    task automatic put_word(logic [7:0] c, logic present, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        char_present <= present;
        end_of_string <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Sends the string in text; with tail_end the string is closed by a word
    // that carries no byte.
    task automatic send_text(bit tail_end);
        bit ends_here;
        for (int i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(29) == 0)
                put_word(8'($urandom_range(255)), 1'b0, 1'b0);
            ends_here = !tail_end && (i == text.size() - 1);
            put_word(text[i], 1'b1, ends_here);
            items_sent++;
        end
        if (tail_end || text.size() == 0)
        begin
            put_word(8'($urandom_range(255)), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    task automatic load(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [5:0] base, bit sgn, bit nar, bit spare);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= CFG_SIGNED;
        cfg_data <= {5'($urandom_range(31)), sgn};
        @(posedge clk);
        cfg_index <= CFG_NARROW;
        cfg_data <= {5'($urandom_range(31)), nar};
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data <= 6'($urandom_range(63));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        sb.base_sel = base;
        sb.sign_mode = sgn;
        sb.narrow = nar;
        cur_base = base;
        cur_signed = sgn;
    endtask

    function automatic logic [7:0] digit_char(int d);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return $urandom_range(1) ? 8'(CH_A_LO + d - 10) : 8'(CH_A_UP + d - 10);
    endfunction

    // Mostly well-formed numbers in the current radix, with boundary values,
    // underscores in prefix mode, and some noise and corrupted bytes.
    task automatic build_text(output bit tail_end);
        int kind;
        int rdx;
        int n;
        logic [63:0] v;
        logic [7:0] digits[$];
        text.delete();
        tail_end = ($urandom_range(7) == 0);
        kind = $urandom_range(99);
        if (kind < 4)
            return;
        if (kind < 12)
        begin
            n = $urandom_range(1, 5);
            repeat (n) text.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(cur_signed ? 2 : 11) == 0)
            text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        rdx = cur_base;
        if (cur_base == 6'd0)
        begin
            case ($urandom_range(5))
                0:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
                    rdx = 16;
                end
                1:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back($urandom_range(1) ? CH_B_LO : CH_B_UP);
                    rdx = 2;
                end
                2:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back($urandom_range(1) ? CH_O_LO : CH_O_UP);
                    rdx = 8;
                end
                3:
                begin
                    text.push_back(CH_ZERO);
                    rdx = 8;
                end
                default:
                    rdx = 10;
            endcase
        end
        else if (cur_base < 6'd2 || cur_base > 6'd36)
        begin
            rdx = 10;
        end
        if (kind < 40)
        begin
            case ($urandom_range(10))
                0: v = 64'h7FFF_FFFF_FFFF_FFFF;
                1: v = 64'h8000_0000_0000_0000;
                2: v = 64'h8000_0000_0000_0001;
                3: v = 64'hFFFF_FFFF_FFFF_FFFF;
                4: v = 64'hFFFF_FFFF_FFFF_FFFE;
                5: v = 64'h0000_0000_7FFF_FFFF;
                6: v = 64'h0000_0000_8000_0000;
                7: v = 64'h0000_0000_8000_0001;
                8: v = 64'd0;
                9: v = {$urandom, $urandom};
                default: v = 64'($urandom);
            endcase
            do
            begin
                digits.push_front(digit_char(int'(v % 64'(rdx))));
                v = v / 64'(rdx);
            end
            while (v != 0);
            // One more digit pushes a limit value past the top.
            if ($urandom_range(3) == 0)
                digits.push_back(digit_char($urandom_range(rdx - 1)));
        end
        else
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 8);
            repeat (n) digits.push_back(digit_char($urandom_range(rdx - 1)));
        end
        if (cur_base == 6'd0 && rdx == 10 && digits.size() > 0 && digits[0] == CH_ZERO
            && $urandom_range(3) != 0)
            digits[0] = digit_char($urandom_range(1, 9));
        foreach (digits[i])
            text.push_back(digits[i]);
        if (cur_base == 6'd0 ? ($urandom_range(2) == 0) : ($urandom_range(19) == 0))
        begin
            repeat ($urandom_range(1, 2))
                text.insert($urandom_range(text.size()), CH_UNDER);
        end
        if (text.size() > 0 && $urandom_range(11) == 0)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    endtask

    function automatic logic [7:0] phase_setting(int p);
        logic [5:0] b;
        case (p)
            0: return {6'd10, 1'b1, 1'b0};
            1: return {6'd0, 1'b1, 1'b0};
            2: return {6'd0, 1'b0, 1'b0};
            3: return {6'd16, 1'b1, 1'b1};
            4: return {6'd2, 1'b0, 1'b0};
            5: return {6'd36, 1'b1, 1'b0};
            6: return {6'd8, 1'b1, 1'b1};
            7: return {6'd0, 1'b1, 1'b1};
            8: return {6'd63, 1'b0, 1'b1};
            9: return {6'd1, 1'b1, 1'b0};
            10: return {6'd36, 1'b0, 1'b1};
            11: return {6'd2, 1'b1, 1'b1};
            default:
            begin
                if ($urandom_range(9) == 0)
                    b = 6'($urandom_range(37, 63));
                else if ($urandom_range(2) == 0)
                    b = 6'd0;
                else
                    b = 6'($urandom_range(2, 36));
                return {b, 1'($urandom_range(1)), 1'($urandom_range(1))};
            end
        endcase
    endfunction

    initial
    begin
        bit tail;
        int budget;
        int start;
        logic [7:0] setting;
        logic [5:0] b;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = '0;
        in_valid = 1'b0;
        char_code = '0;
        char_present = 1'b0;
        end_of_string = 1'b0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked = 0;
        cur_base = 6'd10;
        cur_signed = 1'b1;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: base 10, signed.
        text.delete();
        send_text(1'b1);
        load("-");
        send_text(1'b0);
        put_word(8'($urandom_range(255)), 1'b0, 1'b0);
        load("7");
        send_text(1'b0);
        load("+9");
        send_text(1'b1);
        load("a");
        send_text(1'b0);
        text.delete();
        text.push_back(8'hFF);
        send_text(1'b0);
        text.delete();
        text.push_back(8'h00);
        send_text(1'b0);

        // Bad radix, and an empty string that must still report a syntax error.
        quiesce();
        set_config(6'd1, 1'b1, 1'b0, 1'b0);
        load("5");
        send_text(1'b0);
        text.delete();
        send_text(1'b1);

        // Prefix mode: lone zero, underscore after a prefix, trailing underscore.
        quiesce();
        set_config(6'd0, 1'b1, 1'b0, 1'b1);
        load("0");
        send_text(1'b0);
        load("0x_f");
        send_text(1'b0);
        load("1_");
        send_text(1'b0);
        load("0_7");
        send_text(1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            setting = phase_setting(p);
            b = setting[7:2];
            set_config(b, setting[1], setting[0], 1'b0);
            if (p < 6)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 83;
            end
            else if (p < 12)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Back up the block while the sender keeps offering words.
            if (p == 1)
                hold_asked <= hold_asked + 1;
            budget = (b == 6'd1 || b > 6'd36) ? 25 : 80;
            start = items_sent;
            while (items_sent - start < budget)
            begin
                build_text(tail);
                send_text(tail);
            end
        end
        quiesce();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** string_to_integer_parser: PASSED **");
        else
            $display("** string_to_integer_parser: FAILED **");
        $finish;
    end

endmodule
